// ----- rtl/conv_spike_fanout_assert.svh -----
// Assertion macros for the spike fan-out block.
// CSFO_ASSERT_IMPL checks a consequent in the same cycle, CSFO_ASSERT_NEXT in the next cycle.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef CONV_SPIKE_FANOUT_ASSERT_SVH
`define CONV_SPIKE_FANOUT_ASSERT_SVH
`ifndef SYNTHESIS
`define CSFO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CSFO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSFO_ASSERT_IMPL(lbl, ante, cons, msg)
`define CSFO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/csfo_pkg.sv -----
package csfo_pkg;

  localparam int unsigned KSIDE_MAX = 7;
  localparam int unsigned KDEPTH    = KSIDE_MAX * KSIDE_MAX;

  // Shared divider: 17-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int unsigned DVD_W     = 17;
  localparam int unsigned DSR_W     = 16;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic KIND_SPIKE = 1'b0;
  localparam logic KIND_LOAD  = 1'b1;

  localparam logic [2:0] REG_PRE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_POST_WIDTH  = 3'd1;
  localparam logic [2:0] REG_POST_HEIGHT = 3'd2;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd3;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd4;
  localparam logic [2:0] REG_PAD_ROWS    = 3'd5;
  localparam logic [2:0] REG_PAD_COLS    = 3'd6;
  localparam logic [2:0] REG_STRIDE_PAIR = 3'd7;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- rtl/csfo_div.sv -----
module csfo_div import csfo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DSR_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // Restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    quo_d = {quo_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- rtl/conv_spike_fanout.sv -----
// Convolution-kernel spike fan-out.
// A weight load writes its in-range kernel table entry when accepted. A spike runs three
// passes of the one shared restoring divider (id / pre width, then row and column over
// their strides) plus handoff and window setup, then one target per cycle unless stalled.
// rst_ni clears the registers to their defaults and idles the sequencer; the kernel table is
// not cleared and must be loaded before use.
`include "conv_spike_fanout_assert.svh"

module conv_spike_fanout import csfo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input word stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pre_id[15:0], weight_index[21:16], weight_value[37:22]
  input  logic        s_tuser,   // kind: 0 spike, 1 weight load
  // target stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // post_id[15:0], weight[31:16]
  output logic        m_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_ID  = 3'd1;
  localparam logic [2:0] ST_DIV_ROW = 3'd2;
  localparam logic [2:0] ST_DIV_COL = 3'd3;
  localparam logic [2:0] ST_SETUP   = 3'd4;
  localparam logic [2:0] ST_WALK    = 3'd5;

  typedef struct packed {
    logic       ok;    // at least one window position on the grid
    logic [2:0] lo;    // first window index on the grid
    logic [2:0] hi;    // last window index on the grid
    logic [7:0] base;  // grid coordinate of window index 0, low bits
  } span_t;

  // Range of window indices that land inside [0, size) around a centre.
  function automatic span_t win_span(logic signed [18:0] cen, logic [1:0] half,
                                     logic [7:0] size);
    logic signed [18:0] r0;
    logic signed [18:0] neg_r0;
    logic signed [18:0] two_h;
    logic signed [18:0] top;
    logic signed [18:0] lo;
    logic signed [18:0] hi;
    span_t              s;
    r0     = cen - signed'({17'b0, half});
    neg_r0 = -r0;
    two_h  = signed'({16'b0, half, 1'b0});
    top    = signed'({11'b0, size}) - 19'sd1 - r0;
    lo     = (neg_r0 > 19'sd0) ? neg_r0 : 19'sd0;
    hi     = (top < two_h) ? top : two_h;
    s.ok   = (lo <= hi);
    s.lo   = lo[2:0];
    s.hi   = hi[2:0];
    s.base = r0[7:0];
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [15:0] pre_width_q;
  logic [7:0]  post_width_q, post_height_q;
  logic [2:0]  krows_q, kcols_q;
  logic [7:0]  pad_rows_q, pad_cols_q;
  logic [7:0]  stride_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_width_q   <= 16'd1;
      post_width_q  <= 8'd1;
      post_height_q <= 8'd1;
      krows_q       <= 3'd1;
      kcols_q       <= 3'd1;
      pad_rows_q    <= 8'd0;
      pad_cols_q    <= 8'd0;
      stride_q      <= 8'd17;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_PRE_WIDTH:   pre_width_q   <= pwdata[15:0];
        REG_POST_WIDTH:  post_width_q  <= pwdata[7:0];
        REG_POST_HEIGHT: post_height_q <= pwdata[7:0];
        REG_KERNEL_ROWS: krows_q       <= pwdata[2:0];
        REG_KERNEL_COLS: kcols_q       <= pwdata[2:0];
        REG_PAD_ROWS:    pad_rows_q    <= pwdata[7:0];
        REG_PAD_COLS:    pad_cols_q    <= pwdata[7:0];
        REG_STRIDE_PAIR: stride_q      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PRE_WIDTH:   prdata = {16'b0, pre_width_q};
      REG_POST_WIDTH:  prdata = {24'b0, post_width_q};
      REG_POST_HEIGHT: prdata = {24'b0, post_height_q};
      REG_KERNEL_ROWS: prdata = {29'b0, krows_q};
      REG_KERNEL_COLS: prdata = {29'b0, kcols_q};
      REG_PAD_ROWS:    prdata = {24'b0, pad_rows_q};
      REG_PAD_COLS:    prdata = {24'b0, pad_cols_q};
      REG_STRIDE_PAIR: prdata = {24'b0, stride_q};
      default:         prdata = '0;
    endcase
  end

  // Zero pre width or stride acts as one; the half window is side >> 1.
  logic [15:0] pw_eff;
  logic [3:0]  srow, scol;
  logic [1:0]  hrow, hcol;

  assign pw_eff = (pre_width_q == 16'd0) ? 16'd1 : pre_width_q;
  assign srow   = (stride_q[7:4] == 4'd0) ? 4'd1 : stride_q[7:4];
  assign scol   = (stride_q[3:0] == 4'd0) ? 4'd1 : stride_q[3:0];
  assign hrow   = krows_q[2:1];
  assign hcol   = kcols_q[2:1];

  // ---------------------------------------------------------------------------
  // Input word unpack
  // ---------------------------------------------------------------------------
  logic        in_acc;
  logic [15:0] in_pre_id;
  logic [5:0]  in_widx;
  logic [15:0] in_wval;

  assign in_pre_id = s_tdata[15:0];
  assign in_widx   = s_tdata[21:16];
  assign in_wval   = s_tdata[37:22];

  logic [2:0] state_q;

  assign s_tready = (state_q == ST_IDLE);
  assign in_acc   = s_tvalid & s_tready;

  // ---------------------------------------------------------------------------
  // Kernel table: written by loads, read once per emitted target
  // ---------------------------------------------------------------------------
  logic [15:0] kmem [KDEPTH];
  logic [15:0] wt_q;
  logic [5:0]  widx;
  logic        adv;

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_tuser == KIND_LOAD) && (in_widx < 6'(KDEPTH))) begin
      kmem[in_widx] <= in_wval;
    end
    if (adv) begin
      wt_q <= kmem[widx];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider and centre mapping
  // ---------------------------------------------------------------------------
  div_req_t div_req;
  div_rsp_t div_rsp;

  csfo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [15:0]        col_q;    // pre column, the remainder of the first pass
  logic               neg_q;    // sign of the numerator now in the divider
  logic signed [18:0] cen_row_q, cen_col_q;
  logic [18:0]        row_num, col_num, num, num_mag;
  logic signed [18:0] cen_new;

  // numerator = coord - half + pad; it dips below zero only near the grid origin
  assign row_num = {3'b0, div_rsp.quotient[15:0]} - {17'b0, hrow} + {11'b0, pad_rows_q};
  assign col_num = {3'b0, col_q} - {17'b0, hcol} + {11'b0, pad_cols_q};
  assign num     = (state_q == ST_DIV_ID) ? row_num : col_num;
  assign num_mag = num[18] ? (19'd0 - num) : num;

  // Divide magnitudes, then restore the sign so the quotient truncates toward zero.
  assign cen_new = signed'(neg_q ? (19'd0 - {2'b0, div_rsp.quotient})
                                 : {2'b0, div_rsp.quotient}) + 19'sd1;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, in_pre_id};
    div_req.divisor  = pw_eff;
    case (state_q)
      ST_IDLE: begin
        div_req.start = in_acc && (s_tuser == KIND_SPIKE);
      end
      ST_DIV_ID: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = num_mag[16:0];
        div_req.divisor  = {12'b0, srow};
      end
      ST_DIV_ROW: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = num_mag[16:0];
        div_req.divisor  = {12'b0, scol};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Window walk: only the on-grid rectangle is visited; when not stalled, one target per cycle
  // ---------------------------------------------------------------------------
  span_t      rspan, cspan;
  logic [2:0] wr_q, wc_q, wc_lo_q, wr_hi_q, wc_hi_q;
  logic [7:0] r0_q, c0_q;
  logic [7:0] prow, pcol;
  logic [15:0] prod;
  logic [16:0] id_sum;
  logic        walk_last;
  logic        ovld_q, last_q;
  logic [15:0] pid_q;

  assign rspan = win_span(cen_row_q, hrow, post_height_q);
  assign cspan = win_span(cen_col_q, hcol, post_width_q);

  assign prow      = r0_q + {5'b0, wr_q};
  assign pcol      = c0_q + {5'b0, wc_q};
  assign prod      = {8'b0, prow} * {8'b0, post_width_q};
  assign id_sum    = {1'b0, prod} + {9'b0, pcol};
  assign widx      = ({3'b0, wr_q} * {3'b0, kcols_q}) + {3'b0, wc_q};
  assign walk_last = (wr_q == wr_hi_q) && (wc_q == wc_hi_q);

  // advance when the output slot is empty or being drained this cycle
  assign adv = (state_q == ST_WALK) && (!ovld_q || m_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      neg_q     <= 1'b0;
      cen_row_q <= '0;
      cen_col_q <= '0;
      wr_q      <= '0;
      wc_q      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_tuser == KIND_SPIKE)) begin
            state_q <= ST_DIV_ID;
          end
        end
        ST_DIV_ID: begin
          if (div_rsp.done) begin
            neg_q   <= row_num[18];
            state_q <= ST_DIV_ROW;
          end
        end
        ST_DIV_ROW: begin
          if (div_rsp.done) begin
            cen_row_q <= cen_new;
            neg_q     <= col_num[18];
            state_q   <= ST_DIV_COL;
          end
        end
        ST_DIV_COL: begin
          if (div_rsp.done) begin
            cen_col_q <= cen_new;
            state_q   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          wr_q <= rspan.lo;
          wc_q <= cspan.lo;
          // drop the spike when the window misses the grid
          state_q <= (rspan.ok && cspan.ok) ? ST_WALK : ST_IDLE;
        end
        ST_WALK: begin
          if (adv) begin
            if (walk_last) begin
              state_q <= ST_IDLE;
            end else if (wc_q == wc_hi_q) begin
              wc_q <= wc_lo_q;
              wr_q <= wr_q + 3'd1;
            end else begin
              wc_q <= wc_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Pre column, walk bounds and payload: no reset needed
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV_ID) && div_rsp.done) begin
      col_q <= div_rsp.remainder;
    end
    if (state_q == ST_SETUP) begin
      wc_lo_q <= cspan.lo;
      wr_hi_q <= rspan.hi;
      wc_hi_q <= cspan.hi;
      r0_q    <= rspan.base;
      c0_q    <= cspan.base;
    end
    if (adv) begin
      pid_q  <= id_sum[15:0];
      last_q <= walk_last;
    end
  end

  // Output register: hold the word until taken, load the next on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (adv) begin
      ovld_q <= 1'b1;
    end else if (m_tready) begin
      ovld_q <= 1'b0;
    end
  end

  assign m_tvalid = ovld_q;
  assign m_tdata  = {wt_q, pid_q};
  assign m_tlast  = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSFO_ASSERT_IMPL(a_idle_div_quiet, state_q == ST_IDLE, !div_rsp.busy, "divider busy while idle")
  `CSFO_ASSERT_IMPL(a_done_in_div, div_rsp.done, (state_q == ST_DIV_ID) || (state_q == ST_DIV_ROW) || (state_q == ST_DIV_COL), "divider result outside a divide state")
  `CSFO_ASSERT_IMPL(a_widx_range, state_q == ST_WALK, widx < 6'(KDEPTH), "kernel index past table")
  `CSFO_ASSERT_NEXT(a_last_ends, adv && walk_last, state_q == ST_IDLE, "walk continued past last target")
  `CSFO_ASSERT_NEXT(a_start_busy, div_req.start, div_rsp.busy, "divider did not start")

endmodule
